// ----- rtl/pm25fc_pkg.sv -----
package pm25fc_pkg;

    // Field widths of the command and action beats.
    localparam int CMD_W   = 3;
    localparam int PM_W    = 10;
    localparam int SPEED_W = 7;
    localparam int ACT_W   = 2;

    // Register widths.
    localparam int THR_W   = 10;
    localparam int CLEAN_W = 10;
    localparam int DARK_W  = 14;

    // APB port.
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // Register indexes (byte address is four times the index).
    typedef enum logic [1:0] {
        REG_REDUCTION_THR = 2'd0,
        REG_GOOD_HOLD     = 2'd1,
        REG_DARK_HOLD     = 2'd2
    } reg_idx_t;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_SCAN       = 3'd0,
        CMD_DARK_SCAN  = 3'd1,
        CMD_AUTO_START = 3'd2,
        CMD_AUTO_STOP  = 3'd3,
        CMD_DARK_START = 3'd4,
        CMD_DARK_STOP  = 3'd5
    } cmd_t;

    // Motor and light action codes.
    typedef enum logic [ACT_W-1:0] {
        MOTOR_NONE = 2'd0,
        MOTOR_RUN  = 2'd1,
        MOTOR_STOP = 2'd2
    } motor_act_t;

    typedef enum logic [ACT_W-1:0] {
        LIGHT_NONE = 2'd0,
        LIGHT_ON   = 2'd1,
        LIGHT_OFF  = 2'd2
    } light_act_t;

    // PM2.5 band edges.
    localparam logic [PM_W-1:0] BAND_LOW  = PM_W'(35);
    localparam logic [PM_W-1:0] BAND_MID  = PM_W'(75);
    localparam logic [PM_W-1:0] BAND_HIGH = PM_W'(115);

    // Fan speeds in percent.
    localparam logic [SPEED_W-1:0] SPEED_NIGHT = SPEED_W'(20);
    localparam logic [SPEED_W-1:0] SPEED_LOW   = SPEED_W'(40);
    localparam logic [SPEED_W-1:0] SPEED_MED   = SPEED_W'(60);
    localparam logic [SPEED_W-1:0] SPEED_HIGH  = SPEED_W'(80);
    localparam logic [SPEED_W-1:0] SPEED_FULL  = SPEED_W'(100);

    // Bit positions of the hysteresis flags.
    localparam int FLAG_75_115 = 0;
    localparam int FLAG_35_75  = 1;
    localparam int FLAG_AGAIN  = 2;

    // Register reset values.
    localparam logic signed [THR_W-1:0] RST_REDUCTION_THR = THR_W'(10);
    localparam logic [CLEAN_W-1:0]      RST_GOOD_HOLD     = CLEAN_W'(240);
    localparam logic [DARK_W-1:0]       RST_DARK_HOLD     = DARK_W'(600);

    typedef struct packed {
        logic signed [THR_W-1:0] reduction_thr;
        logic [CLEAN_W-1:0]      good_hold;
        logic [DARK_W-1:0]       dark_hold;
    } cfg_t;

    typedef struct packed {
        logic [PM_W-1:0]    prev_pm25;
        logic [CLEAN_W-1:0] clean_cnt;
        logic [DARK_W-1:0]  dark_cnt;
        logic               fan_stopped;
        logic               auto_suspended;
        logic               dark_seen;
        logic [2:0]         band_flags;
    } ctl_state_t;

    typedef struct packed {
        logic [ACT_W-1:0]   motor_action;
        logic [SPEED_W-1:0] speed_pct;
        logic [ACT_W-1:0]   light_action;
    } result_t;

endpackage

// ----- rtl/pm25fc_if.sv -----
// Command channel: one beat is one command with its reading.
interface pm25fc_sample_if
    import pm25fc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [PM_W-1:0]  pm25_level;
    logic             is_dark;

    modport source (output valid, command, pm25_level, is_dark, input ready);
    modport sink   (input valid, command, pm25_level, is_dark, output ready);
endinterface

// Action channel: one beat is the motor and light action for one command.
interface pm25fc_action_if
    import pm25fc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   motor_action;
    logic [SPEED_W-1:0] speed_pct;
    logic [ACT_W-1:0]   light_action;

    modport source (output valid, motor_action, speed_pct, light_action, input ready);
    modport sink   (input valid, motor_action, speed_pct, light_action, output ready);
endinterface

// ----- rtl/pm25fc_cfg.sv -----
module pm25fc_cfg
    import pm25fc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];
    assign cfg     = cfg_reg;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_REDUCTION_THR: cfg_next.reduction_thr = pwdata[THR_W-1:0];
                REG_GOOD_HOLD:     cfg_next.good_hold     = pwdata[CLEAN_W-1:0];
                REG_DARK_HOLD:     cfg_next.dark_hold     = pwdata[DARK_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reduction_thr <= RST_REDUCTION_THR;
            cfg_reg.good_hold     <= RST_GOOD_HOLD;
            cfg_reg.dark_hold     <= RST_DARK_HOLD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read-back mux.
    always_comb
    begin
        unique case (reg_sel)
            REG_REDUCTION_THR: prdata = DATA_W'($unsigned(cfg_reg.reduction_thr));
            REG_GOOD_HOLD:     prdata = DATA_W'(cfg_reg.good_hold);
            REG_DARK_HOLD:     prdata = DATA_W'(cfg_reg.dark_hold);
            default:           prdata = '0;
        endcase
    end

endmodule

// ----- rtl/pm25fc_step.sv -----
module pm25fc_step
    import pm25fc_pkg::*;
#(
    parameter int unsigned CLEAN_COUNT_CAP = 1000,
    parameter int unsigned DARK_COUNT_CAP  = 10000
)
(
    input  logic [CMD_W-1:0] command,
    input  logic [PM_W-1:0]  pm25_level,
    input  logic             is_dark,
    input  cfg_t             cfg,
    input  ctl_state_t       state,
    output ctl_state_t       state_next,
    output result_t          result
);

    logic signed [PM_W:0] reduction;
    logic signed [PM_W:0] thr_ext;
    logic                 low_drop;
    logic                 is_clean;
    logic [CLEAN_W-1:0]   clean_old;
    logic [CLEAN_W:0]     clean_inc;
    logic [CLEAN_W-1:0]   clean_sat;
    logic [DARK_W:0]      dark_inc;
    logic [DARK_W-1:0]    dark_sat;
    logic                 hold_stop;
    logic [SPEED_W-1:0]   pct;

    // Drop since the last scan reading, compared signed against the threshold.
    assign reduction = $signed({1'b0, state.prev_pm25}) - $signed({1'b0, pm25_level});
    assign thr_ext   = {cfg.reduction_thr[THR_W-1], cfg.reduction_thr};
    assign low_drop  = reduction < thr_ext;
    assign is_clean  = pm25_level < BAND_LOW;

    // Saturating hold counters; auto start clears the clean counter first.
    assign clean_old = (command == CMD_AUTO_START) ? '0 : state.clean_cnt;
    assign clean_inc = {1'b0, clean_old} + (CLEAN_W+1)'(1);
    assign clean_sat = (clean_inc > (CLEAN_W+1)'(CLEAN_COUNT_CAP)) ?
                       CLEAN_W'(CLEAN_COUNT_CAP) : clean_inc[CLEAN_W-1:0];
    assign dark_inc  = {1'b0, state.dark_cnt} + (DARK_W+1)'(1);
    assign dark_sat  = (dark_inc > (DARK_W+1)'(DARK_COUNT_CAP)) ?
                       DARK_W'(DARK_COUNT_CAP) : dark_inc[DARK_W-1:0];

    always_comb
    begin
        state_next           = state;
        result.motor_action  = MOTOR_NONE;
        result.speed_pct     = '0;
        result.light_action  = LIGHT_NONE;
        hold_stop            = 1'b0;
        pct                  = SPEED_LOW;

        unique case (command)
            CMD_SCAN, CMD_AUTO_START:
            begin
                state_next.clean_cnt = clean_old;
                state_next.prev_pm25 = pm25_level;
                if (!state.auto_suspended)
                begin
                    // Clean-air hold: stop the fan once after a long clean spell.
                    if (is_clean)
                    begin
                        state_next.clean_cnt = clean_sat;
                        if (clean_old >= cfg.good_hold)
                        begin
                            hold_stop = 1'b1;
                            if (!state.fan_stopped)
                            begin
                                result.motor_action    = MOTOR_STOP;
                                state_next.fan_stopped = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        state_next.clean_cnt   = '0;
                        state_next.fan_stopped = 1'b0;
                    end

                    // Band selection with hysteresis flags.
                    if (!hold_stop)
                    begin
                        if (pm25_level >= BAND_HIGH)
                        begin
                            pct = SPEED_FULL;
                        end
                        else if (pm25_level >= BAND_MID)
                        begin
                            if (state.band_flags[FLAG_75_115])
                            begin
                                pct = low_drop ? SPEED_FULL : SPEED_HIGH;
                            end
                            else
                            begin
                                pct = state.band_flags[FLAG_AGAIN] ? SPEED_FULL : SPEED_HIGH;
                                state_next.band_flags[FLAG_75_115] = 1'b1;
                            end
                        end
                        else if (pm25_level >= BAND_LOW)
                        begin
                            state_next.band_flags[FLAG_75_115] = 1'b0;
                            pct = SPEED_MED;
                            if (state.band_flags[FLAG_35_75])
                            begin
                                if (low_drop)
                                begin
                                    state_next.band_flags[FLAG_AGAIN] = 1'b1;
                                    pct = SPEED_HIGH;
                                end
                                state_next.band_flags[FLAG_35_75] = 1'b0;
                            end
                            else if (state.band_flags[FLAG_AGAIN])
                            begin
                                pct = low_drop ? SPEED_FULL : SPEED_HIGH;
                            end
                            else
                            begin
                                state_next.band_flags[FLAG_35_75] = 1'b1;
                            end
                        end
                        else
                        begin
                            state_next.band_flags[FLAG_75_115] = 1'b0;
                            state_next.band_flags[FLAG_AGAIN]  = 1'b0;
                            pct = SPEED_LOW;
                        end
                        result.motor_action  = MOTOR_RUN;
                        result.speed_pct     = pct;
                    end
                end
            end

            CMD_DARK_SCAN:
            begin
                if (!is_dark)
                begin
                    if (state.dark_seen)
                    begin
                        result.light_action = LIGHT_ON;
                    end
                    state_next.dark_seen      = 1'b0;
                    state_next.dark_cnt       = '0;
                    state_next.auto_suspended = 1'b0;
                end
                else
                begin
                    if (!state.dark_seen)
                    begin
                        result.light_action = LIGHT_OFF;
                    end
                    state_next.dark_seen = 1'b1;
                    // Dark hold: suspend auto control and run at night speed.
                    if (is_clean)
                    begin
                        state_next.dark_cnt = dark_sat;
                        if (state.dark_cnt >= cfg.dark_hold)
                        begin
                            state_next.auto_suspended = 1'b1;
                            result.motor_action       = MOTOR_RUN;
                            result.speed_pct          = SPEED_NIGHT;
                        end
                    end
                    else
                    begin
                        state_next.dark_cnt       = '0;
                        state_next.auto_suspended = 1'b0;
                    end
                end
            end

            CMD_AUTO_STOP:
            begin
                state_next.band_flags  = '0;
                state_next.fan_stopped = 1'b0;
            end

            CMD_DARK_START:
            begin
                state_next.dark_cnt = '0;
            end

            CMD_DARK_STOP:
            begin
                state_next.auto_suspended = 1'b0;
            end

            default:
            begin
                state_next = state;
            end
        endcase
    end

endmodule

// ----- rtl/pm25_fan_speed_controller.sv -----
// Channel  | Modport | Beat contents
// ---------+---------+---------------------------------------------
// sample   | sink    | command, pm25_level, is_dark
// action   | source  | motor_action, speed_pct, light_action
// APB      | slave   | reduction_threshold, good_hold_ticks, dark_hold_ticks
//
// One action beat per command beat; one beat per cycle sustained while action.ready holds.
// A beat passes the input register, then the state update and result register.
// The combinational state update in the step logic sets the rate.
// rst_n clears the pipeline valids, the controller state and the configuration registers.
// A stalled action beat holds its register; the input register keeps taking
// a beat until it is full, so ready falls only when both stages hold data.
module pm25_fan_speed_controller
    import pm25fc_pkg::*;
#(
    parameter int unsigned CLEAN_COUNT_CAP = 1000,
    parameter int unsigned DARK_COUNT_CAP  = 10000
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    pm25fc_sample_if.sink        sample,
    pm25fc_action_if.source      action,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready
);

    cfg_t             cfg;
    ctl_state_t       state_reg;
    ctl_state_t       state_next;
    result_t          result_comb;
    result_t          result_reg;
    logic             in_valid_reg;
    logic [CMD_W-1:0] command_reg;
    logic [PM_W-1:0]  pm25_level_reg;
    logic             is_dark_reg;
    logic             out_valid_reg;
    logic             advance;
    logic             take;

    pm25fc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pm25fc_step #(
        .CLEAN_COUNT_CAP (CLEAN_COUNT_CAP),
        .DARK_COUNT_CAP  (DARK_COUNT_CAP)
    ) u_step (
        .command    (command_reg),
        .pm25_level (pm25_level_reg),
        .is_dark    (is_dark_reg),
        .cfg        (cfg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_comb)
    );

    // Pipeline flow control.
    assign advance      = in_valid_reg && (!out_valid_reg || action.ready);
    assign sample.ready = !in_valid_reg || advance;
    assign take         = sample.valid && sample.ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            in_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            command_reg    <= sample.command;
            pm25_level_reg <= sample.pm25_level;
            is_dark_reg    <= sample.is_dark;
        end
    end

    // Controller state, updated once per command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || action.ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_comb;
        end
    end

    assign action.valid         = out_valid_reg;
    assign action.motor_action  = result_reg.motor_action;
    assign action.speed_pct     = result_reg.speed_pct;
    assign action.light_action  = result_reg.light_action;

endmodule

// ----- rtl/pm25fc_checker.sv -----
module pm25fc_checker
    import pm25fc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               act_valid,
    input logic               act_ready,
    input logic [ACT_W-1:0]   motor_action,
    input logic [SPEED_W-1:0] speed_pct,
    input logic [ACT_W-1:0]   light_action
);

    // A stalled action beat stays and keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        act_valid && !act_ready |=> act_valid && $stable(motor_action) &&
        $stable(speed_pct) && $stable(light_action))
        else $error("action beat changed while stalled");

    // Speed is reported only with a run action.
    assert property (@(posedge clk) disable iff (!rst_n)
        act_valid && motor_action != MOTOR_RUN |-> speed_pct == '0)
        else $error("speed without run action");

    // A run action carries one of the defined speeds.
    assert property (@(posedge clk) disable iff (!rst_n)
        act_valid && motor_action == MOTOR_RUN |->
        speed_pct == SPEED_NIGHT || speed_pct == SPEED_LOW ||
        speed_pct == SPEED_MED || speed_pct == SPEED_HIGH ||
        speed_pct == SPEED_FULL)
        else $error("undefined run speed");

    // Light changes come from dark scans, which only run at night speed.
    assert property (@(posedge clk) disable iff (!rst_n)
        act_valid && light_action != LIGHT_NONE |->
        motor_action == MOTOR_NONE ||
        (motor_action == MOTOR_RUN && speed_pct == SPEED_NIGHT))
        else $error("light action with a scan motor action");

endmodule

bind pm25_fan_speed_controller pm25fc_checker u_pm25fc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .act_valid     (action.valid),
    .act_ready     (action.ready),
    .motor_action  (action.motor_action),
    .speed_pct     (action.speed_pct),
    .light_action  (action.light_action)
);
